@@ rtl/core/wwf_pkg.sv @@
// Package for the word wrap line folder: widths, character codes, the command
// word passed from the front end to the back end, and the back end states.
// No dependencies.
package wwf_pkg;

  localparam int LINE_WIDTH = 32;
  localparam int CNT_W      = $clog2(LINE_WIDTH + 1);
  localparam int IDX_W      = (LINE_WIDTH > 2) ? $clog2(LINE_WIDTH) : 1;
  localparam int SUM_W      = CNT_W + 1;

  localparam int CQ_DEPTH   = 2;
  localparam int CQ_PTR_W   = (CQ_DEPTH > 2) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = (OQ_DEPTH > 2) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CONT  = 8'h3E;
  localparam logic [7:0] CH_BREAK = 8'h3C;

  // One command per accepted word. A line command emits an optional '>',
  // cnt stored bytes, an optional '<' and a newline, then advances the ring
  // head by adv and optionally writes data at logical position wpos.
  typedef struct packed {
    logic             is_line;
    logic             prefix;
    logic             close;
    logic             wr;
    logic [7:0]       data;
    logic [CNT_W-1:0] wpos;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] adv;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREFIX,
    BK_BODY,
    BK_CLOSE,
    BK_NL
  } back_state_e;

  // Adds an offset to a ring index; the sum stays below twice the ring size.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(LINE_WIDTH)) begin
      sum = sum - SUM_W'(LINE_WIDTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/wwf_front.sv @@
// Front end of the word wrap line folder: classifies each word and keeps the
// fill, blank and continuation state. Depends on wwf_pkg.
module wwf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    text_byte_i,
  input  logic          end_of_stream_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output wwf_pkg::cmd_t cmd_o
);
  import wwf_pkg::*;

  logic [CNT_W-1:0] fill_q, fill_d;
  logic             blank_q, blank_d;
  logic [CNT_W-1:0] bpos_q, bpos_d;
  logic             cont_q, cont_d;

  logic             is_sp;
  logic             bs;
  logic [CNT_W-1:0] bp;
  logic             accept;

  assign accept     = push_i & ~cmd_full_i;
  assign cmd_push_o = accept;
  assign is_sp      = (text_byte_i == CH_SPACE);
  assign bs         = blank_q | is_sp;
  assign bp         = is_sp ? fill_q : bpos_q;

  always_comb begin
    fill_d  = fill_q;
    blank_d = blank_q;
    bpos_d  = bpos_q;
    cont_d  = cont_q;

    cmd_o         = '0;
    cmd_o.data    = text_byte_i;
    cmd_o.prefix  = cont_q;

    if (end_of_stream_i) begin
      cmd_o.is_line = 1'b1;
      cmd_o.cnt     = fill_q;
      fill_d        = '0;
      blank_d       = 1'b0;
      bpos_d        = '0;
      cont_d        = 1'b0;
    end else if (text_byte_i == CH_NL) begin
      cmd_o.is_line = 1'b1;
      cmd_o.cnt     = fill_q;
      fill_d        = '0;
      blank_d       = 1'b0;
      bpos_d        = bp;
      cont_d        = 1'b0;
    end else if (fill_q == CNT_W'(LINE_WIDTH)) begin
      cmd_o.is_line = 1'b1;
      bpos_d        = bp;
      if (!bs) begin
        // No blank to break at: the whole line goes out with a closing mark.
        cmd_o.cnt   = CNT_W'(LINE_WIDTH);
        cmd_o.close = 1'b1;
        cmd_o.wr    = 1'b1;
        fill_d      = CNT_W'(1);
        blank_d     = 1'b0;
        cont_d      = 1'b1;
      end else if (is_sp) begin
        // A space on a full line ends it there and is itself dropped.
        cmd_o.cnt   = CNT_W'(LINE_WIDTH);
        fill_d      = '0;
        blank_d     = 1'b0;
        cont_d      = 1'b0;
      end else begin
        // The text after the blank becomes the head of the next line.
        cmd_o.cnt   = bp;
        cmd_o.adv   = bp + CNT_W'(1);
        cmd_o.wr    = 1'b1;
        cmd_o.wpos  = CNT_W'(LINE_WIDTH - 1) - bp;
        fill_d      = CNT_W'(LINE_WIDTH) - bp;
        blank_d     = 1'b0;
        cont_d      = 1'b0;
      end
    end else begin
      cmd_o.wr   = 1'b1;
      cmd_o.wpos = fill_q;
      fill_d     = fill_q + CNT_W'(1);
      blank_d    = bs;
      bpos_d     = bp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      blank_q <= 1'b0;
      bpos_q  <= '0;
      cont_q  <= 1'b0;
    end else if (accept) begin
      fill_q  <= fill_d;
      blank_q <= blank_d;
      bpos_q  <= bpos_d;
      cont_q  <= cont_d;
    end
  end

endmodule

@@ rtl/core/wwf_cmd_fifo.sv @@
// Short command queue between the front end and the back end of the word
// wrap line folder. Depends on wwf_pkg.
module wwf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wwf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output wwf_pkg::cmd_t data_o,
  output logic          empty_o
);
  import wwf_pkg::*;

  cmd_t                slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/wwf_back.sv @@
// Back end of the word wrap line folder: holds the line store as a ring,
// carries out commands and queues the output words. Depends on wwf_pkg.
module wwf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wwf_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);
  import wwf_pkg::*;

  back_state_e      state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic [7:0]       line_mem_q [LINE_WIDTH];
  logic [7:0]       rdata_q;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;

  // Token register stage that lines up literals with the memory read data.
  logic             tok_vld_q, tok_vld_d;
  logic             tok_mem_q, tok_mem_d;
  logic [7:0]       tok_lit_q, tok_lit_d;
  logic             tok_last_q, tok_last_d;

  out_t                oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic                oq_push;
  logic                oq_pop;
  out_t                oq_in;
  logic                can_emit;

  assign can_emit = ((OQ_CNT_W + 1)'(oq_cnt_q) + (OQ_CNT_W + 1)'(tok_vld_q))
                    < (OQ_CNT_W + 1)'(OQ_DEPTH);

  always_comb begin
    back_state_e after_prefix;
    logic [IDX_W-1:0] head_nxt;

    state_d    = state_q;
    cur_d      = cur_q;
    head_d     = head_q;
    idx_d      = idx_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    waddr      = wrap_add(head_q, cmd_i.wpos);
    wdata      = cmd_i.data;
    raddr      = wrap_add(head_q, idx_q);
    tok_vld_d  = 1'b0;
    tok_mem_d  = 1'b0;
    tok_lit_d  = CH_NL;
    tok_last_d = 1'b0;
    head_nxt   = wrap_add(head_q, cur_q.adv);

    if (cur_q.cnt != '0) begin
      after_prefix = BK_BODY;
    end else if (cur_q.close) begin
      after_prefix = BK_CLOSE;
    end else begin
      after_prefix = BK_NL;
    end

    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_line) begin
            mem_we = 1'b1;
          end else begin
            cur_d = cmd_i;
            idx_d = '0;
            if (cmd_i.prefix) begin
              state_d = BK_PREFIX;
            end else if (cmd_i.cnt != '0) begin
              state_d = BK_BODY;
            end else if (cmd_i.close) begin
              state_d = BK_CLOSE;
            end else begin
              state_d = BK_NL;
            end
          end
        end
      end
      BK_PREFIX: begin
        if (can_emit) begin
          tok_vld_d = 1'b1;
          tok_lit_d = CH_CONT;
          state_d   = after_prefix;
        end
      end
      BK_BODY: begin
        if (can_emit) begin
          tok_vld_d = 1'b1;
          tok_mem_d = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
          if (idx_q + CNT_W'(1) == cur_q.cnt) begin
            state_d = cur_q.close ? BK_CLOSE : BK_NL;
          end
        end
      end
      BK_CLOSE: begin
        if (can_emit) begin
          tok_vld_d = 1'b1;
          tok_lit_d = CH_BREAK;
          state_d   = BK_NL;
        end
      end
      BK_NL: begin
        if (can_emit) begin
          tok_vld_d  = 1'b1;
          tok_lit_d  = CH_NL;
          tok_last_d = 1'b1;
          head_d     = head_nxt;
          // The byte that caused a break is stored after the moved text.
          mem_we     = cur_q.wr;
          waddr      = wrap_add(head_nxt, cur_q.wpos);
          wdata      = cur_q.data;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      head_q    <= '0;
      idx_q     <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      idx_q     <= idx_d;
      tok_vld_q <= tok_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    tok_mem_q  <= tok_mem_d;
    tok_lit_q  <= tok_lit_d;
    tok_last_q <= tok_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[waddr] <= wdata;
    end
    rdata_q <= line_mem_q[raddr];
  end

  // Output word queue.
  assign oq_push    = tok_vld_q;
  assign oq_in.data = tok_mem_q ? rdata_q : tok_lit_q;
  assign oq_in.last = tok_last_q;
  assign empty_o    = (oq_cnt_q == '0);
  assign oq_pop     = pop_i & ~empty_o;
  assign out_byte_o = oq_q[oq_rd_q].data;
  assign out_last_o = oq_q[oq_rd_q].last;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + OQ_CNT_W'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_d = oq_cnt_q - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_push) begin
        oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_in;
    end
  end

endmodule

@@ rtl/core/word_wrap_line_folder.sv @@
// Word wrap line folder, top level: front end, command queue and back end.
// A word that only stores a byte is written when the back end pops it. A word
// that emits a line steps the back end through prefix, text, mark and newline,
// reading text through the single read port of the line store and waiting while
// the output queue lacks room. Reset is asynchronous and clears all control
// state; the line store itself is not cleared and is only read where written.
module word_wrap_line_folder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_stream_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import wwf_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;

  assign full = cmd_full;

  wwf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .text_byte_i     (text_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  wwf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  wwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .out_last_o  (last_of_run_o)
  );

endmodule
